### src/psi_section_assembler_defines.svh
// Assertion macros for the PSI section assembler.
`ifndef PSI_SECTION_ASSEMBLER_DEFINES_SVH
`define PSI_SECTION_ASSEMBLER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/psa_pkg.sv
// Types and constants shared by the PSI section assembler.
package psa_pkg;

    localparam int unsigned HELD_W = 13;

    // Minimum bytes held before the length field is known
    localparam logic [HELD_W-1:0] HDR_FIXED_BYTES = 13'd3;

    // Tables whose length field is 10 bits wide
    localparam logic [7:0] TID_PAT = 8'h00;
    localparam logic [7:0] TID_CAT = 8'h02;

    // Position of the next header byte to capture
    typedef enum logic [3:0] {
        HP_TABLE   = 4'd0,
        HP_LEN_HI  = 4'd1,
        HP_LEN_LO  = 4'd2,
        HP_EXT_HI  = 4'd3,
        HP_EXT_LO  = 4'd4,
        HP_VERSION = 4'd5,
        HP_SECNUM  = 4'd6,
        HP_LASTSEC = 4'd7,
        HP_IDLE    = 4'd8
    } t_hdr_pos;

    typedef struct packed {
        logic [7:0]  table_id;
        logic        syntax_indicator;
        logic [11:0] section_length;
        logic [15:0] extension_id;
        logic [4:0]  version_number;
        logic        current_next;
        logic [7:0]  section_index;
        logic [7:0]  last_section_index;
    } t_hdr;

    typedef struct packed {
        logic [HELD_W-1:0] held_count;
        t_hdr_pos          header_pos;
        t_hdr              hdr;
    } t_state;

    typedef struct packed {
        t_hdr              hdr;
        logic [HELD_W-1:0] byte_slot;
        logic              keep;
        logic              header_valid;
        logic              complete;
    } t_result;

endpackage

### src/psa_if.sv
// Handshake channels of the PSI section assembler: input bytes and results.
interface psa_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, func, data_byte, input ready);
    modport sink   (input valid, func, data_byte, output ready);
endinterface

interface psa_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  table_id;
    logic        syntax_indicator;
    logic [11:0] section_length;
    logic [15:0] extension_id;
    logic [4:0]  version_number;
    logic        current_next;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
    logic [12:0] byte_slot;
    logic        keep;
    logic        header_valid;
    logic        complete;

    modport source (
        output valid, table_id, syntax_indicator, section_length, extension_id,
               version_number, current_next, section_index, last_section_index,
               byte_slot, keep, header_valid, complete,
        input  ready
    );
    modport sink (
        input  valid, table_id, syntax_indicator, section_length, extension_id,
               version_number, current_next, section_index, last_section_index,
               byte_slot, keep, header_valid, complete,
        output ready
    );
endinterface

### src/psa_step.sv
// Next-state and result logic for one section byte.
module psa_step (
    input  psa_pkg::t_state  i_state,
    input  logic             i_func,
    input  logic [7:0]       i_data_byte,
    output psa_pkg::t_state  o_state,
    output psa_pkg::t_result o_result
);

    psa_pkg::t_state                 cur;
    psa_pkg::t_hdr                   hdr;
    psa_pkg::t_hdr_pos               hp_n;
    logic                            open;
    logic                            keep;
    logic [psa_pkg::HELD_W-1:0]      limit;
    logic [psa_pkg::HELD_W-1:0]      held_n;

    always_comb begin
        // A start byte opens a fresh section before it is handled
        cur = i_state;
        if (i_func) begin
            cur.held_count = '0;
            cur.header_pos = psa_pkg::HP_TABLE;
            cur.hdr        = '0;
        end
        open = i_func || (cur.held_count != '0);

        hdr  = cur.hdr;
        hp_n = cur.header_pos;
        if (open && (cur.header_pos != psa_pkg::HP_IDLE)) begin
            case (cur.header_pos)
                psa_pkg::HP_TABLE: begin
                    hdr.table_id = i_data_byte;
                end
                psa_pkg::HP_LEN_HI: begin
                    hdr.syntax_indicator = i_data_byte[7];
                    hdr.section_length   = {i_data_byte[3:0], 8'h00};
                end
                psa_pkg::HP_LEN_LO: begin
                    hdr.section_length = {hdr.section_length[11:8], i_data_byte};
                    if ((hdr.table_id == psa_pkg::TID_PAT) ||
                        (hdr.table_id == psa_pkg::TID_CAT)) begin
                        hdr.section_length[11:10] = 2'b00;
                    end
                end
                psa_pkg::HP_EXT_HI: begin
                    hdr.extension_id[15:8] = i_data_byte;
                end
                psa_pkg::HP_EXT_LO: begin
                    hdr.extension_id[7:0] = i_data_byte;
                end
                psa_pkg::HP_VERSION: begin
                    hdr.version_number = i_data_byte[5:1];
                    hdr.current_next   = i_data_byte[0];
                end
                psa_pkg::HP_SECNUM: begin
                    hdr.section_index = i_data_byte;
                end
                psa_pkg::HP_LASTSEC: begin
                    hdr.last_section_index = i_data_byte;
                end
                default: begin
                end
            endcase
            hp_n = psa_pkg::t_hdr_pos'(cur.header_pos + 4'd1);
        end

        // Keep bytes until length plus the three fixed header bytes are held
        limit  = {1'b0, hdr.section_length} + psa_pkg::HDR_FIXED_BYTES;
        keep   = open && (cur.held_count < limit);
        held_n = keep ? (cur.held_count + 13'd1) : cur.held_count;

        o_state.held_count = held_n;
        o_state.header_pos = hp_n;
        o_state.hdr        = hdr;

        o_result.hdr          = hdr;
        o_result.byte_slot    = keep ? cur.held_count : '0;
        o_result.keep         = keep;
        o_result.header_valid = (held_n != '0) && (hp_n == psa_pkg::HP_IDLE);
        o_result.complete     = held_n >= limit;
    end

endmodule

### src/psi_section_assembler.sv
// Top level of the PSI section assembler: section state, result register, handshakes.
//
// Reassembles one MPEG-2 PSI section from a byte stream. Each accepted input item is one
// byte; func high opens a new section with that byte, func low continues the open one.
// The first eight bytes after a start load the header fields, the length is cut to
// 10 bits for table ids 0x00 and 0x02, and bytes are kept with their slot until
// section_length+3 are held; later bytes are dropped until the next start. Every input
// item gives exactly one result item in the next cycle, carrying the header as it stands
// after that byte. The block takes one item per clock: the whole step is one pass of
// logic from the section state registers into the result register, and a new item is
// accepted whenever the result register is empty or is being emptied in that cycle.
// Only a stalled result (valid high, ready low) holds the input off.
`include "psi_section_assembler_defines.svh"

module psi_section_assembler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psa_in_if.sink        i_in,
    psa_out_if.source     o_out
);

    psa_pkg::t_state  r_state;
    psa_pkg::t_state  n_state;
    psa_pkg::t_result r_res;
    psa_pkg::t_result n_res;
    logic             r_out_valid;
    logic             in_accept;

    // Advance while the result register is free or drains this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    psa_step u_step (
        .i_state     (r_state),
        .i_func      (i_in.func),
        .i_data_byte (i_in.data_byte),
        .o_state     (n_state),
        .o_result    (n_res)
    );

    // Section state: no section open after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.held_count <= '0;
            r_state.header_pos <= psa_pkg::HP_IDLE;
            r_state.hdr        <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.table_id           = r_res.hdr.table_id;
    assign o_out.syntax_indicator   = r_res.hdr.syntax_indicator;
    assign o_out.section_length     = r_res.hdr.section_length;
    assign o_out.extension_id       = r_res.hdr.extension_id;
    assign o_out.version_number     = r_res.hdr.version_number;
    assign o_out.current_next       = r_res.hdr.current_next;
    assign o_out.section_index      = r_res.hdr.section_index;
    assign o_out.last_section_index = r_res.hdr.last_section_index;
    assign o_out.byte_slot          = r_res.byte_slot;
    assign o_out.keep               = r_res.keep;
    assign o_out.header_valid       = r_res.header_valid;
    assign o_out.complete           = r_res.complete;

    // Header capture only runs inside an open section
    `PSA_ASSERT_SAME(a_capture_open, r_state.header_pos != psa_pkg::HP_IDLE, r_state.held_count != '0, "header capture outside an open section")

    // Never hold more than length plus the fixed header bytes
    `PSA_ASSERT_SAME(a_held_bound, 1'b1, r_state.held_count <= ({1'b0, r_state.hdr.section_length} + psa_pkg::HDR_FIXED_BYTES), "held count beyond section end")

    // A stalled result blocks new items
    `PSA_ASSERT_SAME(a_stall_blocks, r_out_valid && !o_out.ready, !i_in.ready, "item accepted over a stalled result")

    // Every accepted item yields a result on the next cycle
    `PSA_ASSERT_NEXT(a_accept_result, in_accept, r_out_valid, "accepted item produced no result")

endmodule

### tb/tb_psi_section_assembler.sv
// Self-checking testbench of the PSI section assembler: directed and random byte streams.
module tb_psi_section_assembler;

    // Each result item is shown from the result register in the cycle after its input item
    localparam int unsigned RESULT_LATENCY = 1;
    localparam int unsigned DRAIN_CYCLES   = RESULT_LATENCY + 8;
    // Longest correct stretch without a handshake is the receiver hold-off below
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned IDLE_LIMIT     = 2000;
    localparam int unsigned RANDOM_ITEMS   = 370;
    localparam int unsigned PRINT_LIMIT    = 30;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic i_clk;
    logic i_rst_n;

    psa_in_if  in_if ();
    psa_out_if out_if ();

    psi_section_assembler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Section state as the block should hold it
    logic [psa_pkg::HELD_W-1:0] held_bytes;
    psa_pkg::t_hdr_pos          hdr_pos;
    psa_pkg::t_hdr              hdr;

    // One expected result item per accepted byte, oldest first
    psa_pkg::t_result           byte_results_due[$];

    int unsigned       mismatch_count;
    int unsigned       sent_items;
    int unsigned       burst_left;
    int unsigned       idle_cycles;
    bit                hold_request;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Section predictor: advance the state by one byte and return the
    // result item that this byte should give.
    // ------------------------------------------------------------------
    function automatic void clear_section();
        held_bytes = '0;
        hdr_pos    = psa_pkg::HP_IDLE;
        hdr        = '0;
    endfunction

    function automatic psa_pkg::t_result assemble_byte(input logic       opens,
                                                       input logic [7:0] b);
        psa_pkg::t_result r;
        logic    is_open;
        logic    takes;
        int      end_slot;
        r = '0;
        // A start wipes the header and restarts capture at the table id
        if (opens) begin
            held_bytes = '0;
            hdr_pos    = psa_pkg::HP_TABLE;
            hdr        = '0;
        end
        is_open = opens || held_bytes != '0;

        // Header capture runs over eight bytes, even past a short section's end
        if (is_open && hdr_pos < psa_pkg::HP_IDLE) begin
            case (hdr_pos)
                psa_pkg::HP_TABLE: begin
                    hdr.table_id = b;
                end
                psa_pkg::HP_LEN_HI: begin
                    hdr.syntax_indicator = b[7];
                    hdr.section_length   = {b[3:0], 8'h00};
                end
                psa_pkg::HP_LEN_LO: begin
                    hdr.section_length[7:0] = b;
                    // PAT and CAT carry only a 10-bit length
                    if (hdr.table_id == psa_pkg::TID_PAT ||
                        hdr.table_id == psa_pkg::TID_CAT) begin
                        hdr.section_length[11:10] = 2'b00;
                    end
                end
                psa_pkg::HP_EXT_HI: begin
                    hdr.extension_id[15:8] = b;
                end
                psa_pkg::HP_EXT_LO: begin
                    hdr.extension_id[7:0] = b;
                end
                psa_pkg::HP_VERSION: begin
                    hdr.version_number = b[5:1];
                    hdr.current_next   = b[0];
                end
                psa_pkg::HP_SECNUM: begin
                    hdr.section_index = b;
                end
                psa_pkg::HP_LASTSEC: begin
                    hdr.last_section_index = b;
                end
                default: begin
                end
            endcase
            hdr_pos = psa_pkg::t_hdr_pos'(hdr_pos + 4'd1);
        end

        // Keep unconditionally until the length is known, then up to length+3
        end_slot = int'(hdr.section_length) + int'(psa_pkg::HDR_FIXED_BYTES);
        takes = is_open && (held_bytes < psa_pkg::HDR_FIXED_BYTES ||
                            int'(held_bytes) < end_slot);
        if (takes) begin
            r.byte_slot = held_bytes;
            held_bytes  = held_bytes + 13'd1;
        end

        r.hdr          = hdr;
        r.keep         = takes;
        r.header_valid = held_bytes != '0 && hdr_pos == psa_pkg::HP_IDLE;
        r.complete     = held_bytes >= psa_pkg::HDR_FIXED_BYTES && int'(held_bytes) >= end_slot;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one byte, hold it until accepted, then log what the
    // block should answer. Bursts of random length with gaps between.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic opens, input logic [7:0] b);
        psa_pkg::t_result due;
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // Now and then a long burst, so stretches without gaps occur too
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        in_if.valid     <= 1'b1;
        in_if.func      <= opens;
        in_if.data_byte <= b;
        do @(posedge i_clk); while ((in_if.valid && in_if.ready) !== 1'b1);
        due = assemble_byte(opens, b);
        byte_results_due.push_back(due);
        sent_items++;
        burst_left--;
    endtask

    // Send a section opening: table id, then the two length bytes for body_len,
    // then random content, n_bytes in all (fewer than three cuts it short).
    task automatic send_section(input logic [7:0] tid, input int unsigned body_len,
                                input int unsigned n_bytes);
        logic [11:0] len_field;
        logic [7:0]  b;
        len_field = body_len[11:0];
        // Upper length bits that the 10-bit tables drop get random values
        if (tid == psa_pkg::TID_PAT || tid == psa_pkg::TID_CAT) begin
            len_field[11:10] = 2'($urandom_range(0, 3));
        end
        for (int unsigned i = 0; i < n_bytes; i++) begin
            case (i)
                0:       b = tid;
                1:       b = {4'($urandom_range(0, 15)), len_field[11:8]};
                2:       b = len_field[7:0];
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(i == 0, b);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready follows a stall pattern of its own, and on request
    // holds off for HOLD_CYCLES so that the block fills and stalls input.
    // ------------------------------------------------------------------
    initial begin
        t_stall_mode stall_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        stall_mode = STALL_NONE;
        mode_left  = 0;
        hold_left  = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left  = $urandom_range(8, 64);
                end
                mode_left--;
                case (stall_mode)
                    STALL_NONE:   out_if.ready <= 1'b1;
                    STALL_LIGHT:  out_if.ready <= $urandom_range(0, 3) != 0;
                    STALL_HEAVY:  out_if.ready <= $urandom_range(0, 3) == 0;
                    STALL_TOGGLE: out_if.ready <= ~out_if.ready;
                    default:      out_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] MISMATCH %s", $realtime, what);
        end
    endtask

    task automatic check_field(input string field_name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", field_name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        psa_pkg::t_result due;
        if (i_rst_n === 1'b1 && (out_if.valid && out_if.ready) === 1'b1) begin
            if (byte_results_due.size() == 0) begin
                report_mismatch("result item with none outstanding");
            end else begin
                due = byte_results_due.pop_front();
                check_field("table_id", 16'(out_if.table_id), 16'(due.hdr.table_id));
                check_field("syntax_indicator", 16'(out_if.syntax_indicator),
                            16'(due.hdr.syntax_indicator));
                check_field("section_length", 16'(out_if.section_length),
                            16'(due.hdr.section_length));
                check_field("extension_id", out_if.extension_id, due.hdr.extension_id);
                check_field("version_number", 16'(out_if.version_number),
                            16'(due.hdr.version_number));
                check_field("current_next", 16'(out_if.current_next),
                            16'(due.hdr.current_next));
                check_field("section_index", 16'(out_if.section_index),
                            16'(due.hdr.section_index));
                check_field("last_section_index", 16'(out_if.last_section_index),
                            16'(due.hdr.last_section_index));
                check_field("byte_slot", 16'(out_if.byte_slot), 16'(due.byte_slot));
                check_field("keep", 16'(out_if.keep), 16'(due.keep));
                check_field("header_valid", 16'(out_if.header_valid), 16'(due.header_valid));
                check_field("complete", 16'(out_if.complete), 16'(due.complete));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no item moves on either side for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((in_if.valid && in_if.ready) === 1'b1 ||
                (out_if.valid && out_if.ready) === 1'b1) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("[%0t] watchdog: no handshake for %0d cycles",
                             $realtime, IDLE_LIMIT);
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Continuation bytes with nothing open: dropped, header stays clear
    task automatic test_nothing_open();
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h5A);
    endtask

    // PAT with both masked upper length bits set: the 10-bit mask leaves length 5,
    // so exactly the eight header bytes are kept; extreme field values
    task automatic test_pat_length_mask();
        send_byte(1'b1, psa_pkg::TID_PAT);
        send_byte(1'b0, 8'hFC);
        send_byte(1'b0, 8'h05);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hA5);
        send_byte(1'b0, 8'h3C);
    endtask

    // CAT of length zero: complete after three bytes, yet the header keeps
    // filling from the dropped bytes that follow
    task automatic test_short_section();
        send_byte(1'b1, psa_pkg::TID_CAT);
        send_byte(1'b0, 8'h30);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h12);
        send_byte(1'b0, 8'h34);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hEE);
    endtask

    // A start in the middle of a section abandons it
    task automatic test_restart();
        send_byte(1'b1, 8'h01);
        send_byte(1'b0, 8'h80);
        send_byte(1'b0, 8'h10);
        send_byte(1'b1, 8'h40);
        send_byte(1'b0, 8'h00);
    endtask

    // Largest 12-bit length: the section end sits at slot 4098, so every
    // byte of a short run is kept and complete stays low
    task automatic test_largest_length();
        send_section(8'hFF, 4095, 24);
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_request = 1'b1;
        burst_left   = 64;
        send_section(8'($urandom_range(0, 255)), 30, 33);
    endtask

    // Mostly well-formed sections with random content, plus noise and cut sections
    task automatic test_random_sections();
        int unsigned goal;
        int unsigned pick;
        int unsigned body_len;
        int unsigned n_bytes;
        logic [7:0]  tid;
        goal = sent_items + RANDOM_ITEMS;
        while (sent_items < goal) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                case ($urandom_range(0, 3))
                    0:       tid = psa_pkg::TID_PAT;
                    1:       tid = psa_pkg::TID_CAT;
                    default: tid = 8'($urandom_range(0, 255));
                endcase
                body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
                                                       : $urandom_range(0, 24);
                n_bytes  = body_len + 3;
                if ($urandom_range(0, 5) == 0) begin
                    n_bytes = $urandom_range(1, n_bytes);
                end else begin
                    n_bytes = n_bytes + $urandom_range(0, 3);
                end
                send_section(tid, body_len, n_bytes);
            end else if (pick <= 8) begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
                end
            end else begin
                // Broken start: arbitrary length, cut after a few bytes
                send_section(8'($urandom_range(0, 255)), $urandom_range(0, 4095),
                             $urandom_range(1, 10));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        mismatch_count = 0;
        sent_items     = 0;
        burst_left     = 0;
        idle_cycles    = 0;
        hold_request   = 1'b0;
        clear_section();
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.func      <= 1'b0;
        in_if.data_byte <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_nothing_open();
        test_pat_length_mask();
        test_short_section();
        test_restart();
        test_largest_length();
        test_backpressure();
        test_random_sections();

        in_if.valid <= 1'b0;
        // Drain: the watchdog bounds this wait
        while (byte_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (byte_results_due.size() != 0) begin
            report_mismatch($sformatf("%0d result items never arrived",
                                      byte_results_due.size()));
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
